@@ rtl/cbu_pkg.sv @@
//------------------------------------------------------------------------------
// cbu_pkg
// Shared types and constants for the character buffer with undo and redo.
//------------------------------------------------------------------------------
`default_nettype none

package cbu_pkg;

  localparam int CBU_BUFFER_DEPTH = 256;
  localparam int CBU_STACK_DEPTH  = 256;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_UNDO   = 3'd2;
  localparam logic [2:0] OP_REDO   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] position;
    logic [7:0] char_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [8:0] buffer_length;
    logic [1:0] status;
  } rsp_t;

  // edit record: kind set for a delete
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic [7:0] pos;
  } rec_t;

  typedef struct packed {
    logic       ins_en;
    logic       del_en;
    logic [7:0] pos;
    logic [7:0] ch;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/cbu_cell.sv @@
//------------------------------------------------------------------------------
// cbu_cell
// One character slot of the buffer chain; shifts right on insert, left on delete.
//------------------------------------------------------------------------------
`default_nettype none

module cbu_cell #(
  parameter int IDX = 0
) (
  input  wire                    clk,
  input  cbu_pkg::cell_ctrl_t    ctrl,
  input  wire  [7:0]             left,
  input  wire  [7:0]             right,
  output logic [7:0]             q
);
  import cbu_pkg::*;

  localparam int IdxBits = (IDX > 0) ? $clog2(IDX + 1) : 1;
  localparam int CmpW    = (IdxBits > 8) ? IdxBits : 8;
  localparam logic [CmpW-1:0] MyIdx = CmpW'(IDX);

  logic [CmpW-1:0] pos_c;
  logic            above;
  logic            at;

  assign pos_c = CmpW'(ctrl.pos);
  assign above = MyIdx > pos_c;
  assign at    = MyIdx == pos_c;

  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (above) begin
        q <= left;
      end else if (at) begin
        q <= ctrl.ch;
      end
    end else if (ctrl.del_en && (above || at)) begin
      q <= right;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cbu_stack.sv @@
//------------------------------------------------------------------------------
// cbu_stack
// Record store for one edit stack; one write port, registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module cbu_stack #(
  parameter int DEPTH = 256
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
  input  cbu_pkg::rec_t                wr_data,
  input  wire                          rd_en,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
  output cbu_pkg::rec_t                rd_data
);
  import cbu_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/char_buffer_with_undo_redo.sv @@
// Flow: the stack tops are read at command accept; the edit step then commits and registers the response.
// A new command is taken only after the edit step commits; the edit step shifts the whole cell chain at once.
// A waiting response does not block the next command; the edit step stalls only when
// the response register is still full.
// Reset: clears lengths, stack counts and handshake state; buffer and stacks are not cleared.
//------------------------------------------------------------------------------
// char_buffer_with_undo_redo
// Character buffer held in a chain of cells, with undo and redo record stacks.
//------------------------------------------------------------------------------
`default_nettype none

module char_buffer_with_undo_redo #(
  parameter int BUFFER_DEPTH = cbu_pkg::CBU_BUFFER_DEPTH,
  parameter int STACK_DEPTH  = cbu_pkg::CBU_STACK_DEPTH
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            cmd_valid,
  output logic           cmd_ready,
  input  cbu_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  wire            rsp_ready,
  output cbu_pkg::rsp_t  rsp
);
  import cbu_pkg::*;

  localparam int IW   = $clog2(BUFFER_DEPTH);
  localparam int LW   = $clog2(BUFFER_DEPTH + 1);
  localparam int SW   = $clog2(STACK_DEPTH);
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int CmpW = (LW > 8) ? LW : 8;

  state_t         state;
  state_t         state_next;
  cmd_t           cmd_q;
  logic [LW-1:0]  text_len;
  logic [CW-1:0]  undo_cnt;
  logic [CW-1:0]  redo_cnt;
  rec_t           undo_top;
  rec_t           redo_top;

  logic           accept;
  logic           commit;
  cell_ctrl_t     ctrl;
  logic [7:0]     cell_q [BUFFER_DEPTH];
  logic [7:0]     at_char;

  logic           u_wr_en;
  logic [SW-1:0]  u_wr_addr;
  rec_t           u_wr_data;
  logic           r_wr_en;
  logic [SW-1:0]  r_wr_addr;
  rec_t           r_wr_data;

  logic           edit;
  logic           eff_del;
  logic [7:0]     epos;
  logic [7:0]     ech;
  logic           dest_full;
  logic [CmpW-1:0] pos_c;
  logic [CmpW-1:0] len_c;
  status_t        st;
  logic [7:0]     got;
  logic           done;
  logic [LW-1:0]  len_next;
  logic [CW-1:0]  undo_cnt_next;
  logic [CW-1:0]  redo_cnt_next;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign commit    = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign at_char   = cell_q[IW'(cmd_q.position)];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  // edit decode
  always_comb begin
    edit      = 1'b0;
    eff_del   = 1'b0;
    epos      = cmd_q.position;
    ech       = cmd_q.char_in;
    dest_full = 1'b0;
    st        = ST_DONE;
    got       = 8'd0;
    case (cmd_q.opcode)
      OP_INSERT: begin
        edit      = 1'b1;
        dest_full = (undo_cnt == CW'(STACK_DEPTH));
      end
      OP_DELETE: begin
        edit      = 1'b1;
        eff_del   = 1'b1;
        ech       = at_char;
        dest_full = (undo_cnt == CW'(STACK_DEPTH));
      end
      OP_UNDO: begin
        edit      = (undo_cnt != '0);
        eff_del   = !undo_top.kind;
        epos      = undo_top.pos;
        ech       = undo_top.ch;
        dest_full = (redo_cnt == CW'(STACK_DEPTH));
        if (undo_cnt == '0) st = ST_EMPTY;
      end
      OP_REDO: begin
        edit      = (redo_cnt != '0);
        eff_del   = redo_top.kind;
        epos      = redo_top.pos;
        ech       = redo_top.ch;
        dest_full = (undo_cnt == CW'(STACK_DEPTH));
        if (redo_cnt == '0) st = ST_EMPTY;
      end
      default: ;
    endcase

    pos_c = CmpW'(epos);
    len_c = CmpW'(text_len);

    if (edit) begin
      if (eff_del) begin
        if (pos_c >= len_c) st = ST_BADPOS;
        else if (dest_full) st = ST_FULL;
      end else begin
        if (pos_c > len_c) st = ST_BADPOS;
        else if (text_len == LW'(BUFFER_DEPTH) || dest_full) st = ST_FULL;
      end
    end

    if (cmd_q.opcode == OP_READ) begin
      if (CmpW'(cmd_q.position) < len_c) got = at_char;
      else st = ST_BADPOS;
    end

    done = commit && edit && (st == ST_DONE);
  end

  // stack and length updates
  always_comb begin
    len_next      = text_len;
    undo_cnt_next = undo_cnt;
    redo_cnt_next = redo_cnt;
    u_wr_en       = 1'b0;
    u_wr_addr     = SW'(undo_cnt);
    u_wr_data     = redo_top;
    r_wr_en       = 1'b0;
    r_wr_addr     = SW'(redo_cnt);
    r_wr_data     = undo_top;
    if (done) begin
      len_next = eff_del ? (text_len - LW'(1)) : (text_len + LW'(1));
      case (cmd_q.opcode)
        OP_UNDO: begin
          undo_cnt_next = undo_cnt - CW'(1);
          redo_cnt_next = redo_cnt + CW'(1);
          r_wr_en       = 1'b1;
        end
        OP_REDO: begin
          redo_cnt_next = redo_cnt - CW'(1);
          undo_cnt_next = undo_cnt + CW'(1);
          u_wr_en       = 1'b1;
        end
        default: begin
          undo_cnt_next = undo_cnt + CW'(1);
          u_wr_en       = 1'b1;
          u_wr_data     = '{kind: eff_del, ch: ech, pos: epos};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_len <= '0;
      undo_cnt <= '0;
      redo_cnt <= '0;
    end else begin
      text_len <= len_next;
      undo_cnt <= undo_cnt_next;
      redo_cnt <= redo_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.char_out      <= got;
      rsp.buffer_length <= 9'(len_next);
      rsp.status        <= st;
    end
  end

  assign ctrl = '{ins_en: done && !eff_del, del_en: done && eff_del, pos: epos, ch: ech};

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    logic [7:0] left;
    logic [7:0] right;
    if (i == 0) begin : g_first
      assign left = ech;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == BUFFER_DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    cbu_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .q     (cell_q[i])
    );
  end

  cbu_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_undo (
    .clk     (clk),
    .wr_en   (u_wr_en),
    .wr_addr (u_wr_addr),
    .wr_data (u_wr_data),
    .rd_en   (accept),
    .rd_addr (SW'(undo_cnt - CW'(1))),
    .rd_data (undo_top)
  );

  cbu_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_redo (
    .clk     (clk),
    .wr_en   (r_wr_en),
    .wr_addr (r_wr_addr),
    .wr_data (r_wr_data),
    .rd_en   (accept),
    .rd_addr (SW'(redo_cnt - CW'(1))),
    .rd_data (redo_top)
  );

endmodule

`default_nettype wire
